// ===== sv/assert_macros.svh =====
// assertion macros shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== sv/ctk_pkg.sv =====
// types, constants and helper functions of the tokenizer
package ctk_pkg;

  localparam int PosW     = 16;
  localparam int KwChars  = 6;
  localparam int PrefixW  = 8 * KwChars;
  localparam int WlW      = $clog2(KwChars + 2);
  localparam int NumW     = 31;
  localparam int KindW    = 5;
  localparam int ErrW     = 2;
  localparam int InDepth  = 2;
  localparam int InPtrW   = $clog2(InDepth);
  localparam int InCntW   = $clog2(InDepth + 1);
  localparam int BndDepth = 4;
  localparam int BndIdxW  = $clog2(BndDepth);
  localparam int BndCntW  = $clog2(BndDepth + 1);
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
  localparam logic [NumW-1:0] NumMax = {NumW{1'b1}};

  localparam logic [KindW-1:0] KindEnd    = 5'd0;
  localparam logic [KindW-1:0] KindIdent  = 5'd1;
  localparam logic [KindW-1:0] KindNumber = 5'd2;
  localparam logic [KindW-1:0] KindString = 5'd3;
  localparam logic [KindW-1:0] KindLparen = 5'd4;
  localparam logic [KindW-1:0] KindRparen = 5'd5;
  localparam logic [KindW-1:0] KindLbrace = 5'd6;
  localparam logic [KindW-1:0] KindRbrace = 5'd7;
  localparam logic [KindW-1:0] KindComma  = 5'd8;
  localparam logic [KindW-1:0] KindSemi   = 5'd9;
  localparam logic [KindW-1:0] KindPlus   = 5'd10;
  localparam logic [KindW-1:0] KindMinus  = 5'd11;
  localparam logic [KindW-1:0] KindStar   = 5'd12;
  localparam logic [KindW-1:0] KindSlash  = 5'd13;
  localparam logic [KindW-1:0] KindAssign = 5'd14;
  localparam logic [KindW-1:0] KindEq     = 5'd15;
  localparam logic [KindW-1:0] KindNe     = 5'd16;
  localparam logic [KindW-1:0] KindLt     = 5'd17;
  localparam logic [KindW-1:0] KindLe     = 5'd18;
  localparam logic [KindW-1:0] KindGt     = 5'd19;
  localparam logic [KindW-1:0] KindGe     = 5'd20;
  localparam logic [KindW-1:0] KindInt    = 5'd21;
  localparam logic [KindW-1:0] KindReturn = 5'd22;
  localparam logic [KindW-1:0] KindIf     = 5'd23;
  localparam logic [KindW-1:0] KindElse   = 5'd24;
  localparam logic [KindW-1:0] KindWhile  = 5'd25;
  localparam logic [KindW-1:0] KindError  = 5'd26;

  localparam logic [ErrW-1:0] ErrUnexp  = 2'd0;
  localparam logic [ErrW-1:0] ErrBang   = 2'd1;
  localparam logic [ErrW-1:0] ErrUnterm = 2'd2;
  localparam logic [ErrW-1:0] ErrRange  = 2'd3;

  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChEq    = "=";
  localparam logic [7:0] ChBang  = "!";
  localparam logic [7:0] ChLt    = "<";
  localparam logic [7:0] ChGt    = ">";
  localparam logic [7:0] ChQuote = "\"";
  localparam logic [7:0] ChBslash = "\\";

  localparam logic [PrefixW-1:0] KwInt    = PrefixW'("int");
  localparam logic [PrefixW-1:0] KwReturn = PrefixW'("return");
  localparam logic [PrefixW-1:0] KwIf     = PrefixW'("if");
  localparam logic [PrefixW-1:0] KwElse   = PrefixW'("else");
  localparam logic [PrefixW-1:0] KwWhile  = PrefixW'("while");

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last_of_source;
  } in_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ErrW-1:0]  error_code;
    logic [NumW-1:0]  number_value;
    logic [7:0]       text_byte;
    logic             text_valid;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  column;
    logic             last;
  } res_t;

  // classified source byte
  typedef struct packed {
    logic [7:0]       ch;
    logic             fin;
    logic             alpha;
    logic             digit;
    logic             space;
    logic             held;
    logic [KindW-1:0] punct;
  } class_t;

  typedef struct packed {
    logic   valid;
    class_t item;
  } fq_t;

  typedef struct packed {
    logic valid;
    res_t data;
  } oq_wr_t;

  function automatic logic [KindW-1:0] kw_kind(logic [PrefixW-1:0] wp, logic [WlW-1:0] wl);
    logic [KindW-1:0] k;
    k = KindIdent;
    if (wl == WlW'(3) && wp == KwInt) k = KindInt;
    if (wl == WlW'(6) && wp == KwReturn) k = KindReturn;
    if (wl == WlW'(2) && wp == KwIf) k = KindIf;
    if (wl == WlW'(4) && wp == KwElse) k = KindElse;
    if (wl == WlW'(5) && wp == KwWhile) k = KindWhile;
    return k;
  endfunction

  function automatic res_t mk_res(logic [KindW-1:0] kind, logic [ErrW-1:0] err,
                                  logic [NumW-1:0] num, logic [7:0] txt, logic tv,
                                  logic [PosW-1:0] ln, logic [PosW-1:0] col);
    res_t r;
    r.kind         = kind;
    r.error_code   = err;
    r.number_value = num;
    r.text_byte    = txt;
    r.text_valid   = tv;
    r.line         = ln;
    r.column       = col;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/c_subset_tokenizer_top.sv =====
// top level of the streaming tokenizer for a small C subset
// Source bytes enter through a queue-style push port, one per cycle while the input queue
// is not full, and come out as token, text and error transactions on a queue-style pop
// port. The scanner takes one byte per cycle as long as each byte yields at most one result
// and the output queue has room; a byte that yields several results (up to four, e.g. a
// flushed operator, a punctuation token and the end token) holds the scanner while its
// result bundle drains one transaction per cycle, while the queue has room, into the
// four-deep output queue. Input queue, scanner and output queue each register in turn.
// Identifier and string text streams out byte by byte ahead of the finishing token;
// after an error, bytes are dropped until the byte flagged as last of the source,
// which always ends with an end token and returns the scanner to its reset state.
module c_subset_tokenizer_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  ctk_pkg::in_t   in_data_i,
  output logic           empty,
  input  logic           pop,
  output ctk_pkg::res_t  result_o
);
  import ctk_pkg::*;

  fq_t     fq;
  logic    take;
  oq_wr_t  oq_wr;
  logic    oq_ready;

  ctk_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .fq_o      (fq),
    .take_i    (take)
  );

  ctk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fq_i       (fq),
    .take_o     (take),
    .oq_o       (oq_wr),
    .oq_ready_i (oq_ready)
  );

  ctk_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (oq_wr),
    .ready_o  (oq_ready),
    .empty_o  (empty),
    .pop_i    (pop),
    .result_o (result_o)
  );

endmodule

// ===== sv/ctk_front.sv =====
// input side: byte classification and a short queue toward the scanner
`include "assert_macros.svh"
module ctk_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  ctk_pkg::in_t  in_data_i,
  output ctk_pkg::fq_t  fq_o,
  input  logic          take_i
);
  import ctk_pkg::*;

  class_t             cls;
  class_t             q_q [InDepth];
  logic [InPtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [InCntW-1:0]  cnt_q, cnt_d;
  logic               wr, rd;
  logic [7:0]         ch;

  assign ch = in_data_i.byte_req;

  always_comb begin
    cls.ch    = ch;
    cls.fin   = in_data_i.last_of_source;
    cls.alpha = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
    cls.digit = ch >= "0" && ch <= "9";
    cls.space = ch == " " || (ch >= ChTab && ch <= ChCr);
    cls.held  = ch == ChSlash || ch == ChEq || ch == ChBang || ch == ChLt || ch == ChGt;
    case (ch)
      "(":     cls.punct = KindLparen;
      ")":     cls.punct = KindRparen;
      "{":     cls.punct = KindLbrace;
      "}":     cls.punct = KindRbrace;
      ",":     cls.punct = KindComma;
      ";":     cls.punct = KindSemi;
      "+":     cls.punct = KindPlus;
      "-":     cls.punct = KindMinus;
      "*":     cls.punct = KindStar;
      default: cls.punct = KindEnd;
    endcase
  end

  assign full_o     = cnt_q == InCntW'(InDepth);
  assign wr         = push_i && !full_o;
  assign rd         = take_i && cnt_q != '0;
  assign fq_o.valid = cnt_q != '0;
  assign fq_o.item  = q_q[rptr_q];

  always_comb begin
    wptr_d = wr ? wptr_q + InPtrW'(1) : wptr_q;
    rptr_d = rd ? rptr_q + InPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + InCntW'(wr) - InCntW'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      q_q[wptr_q] <= cls;
    end
  end

  `ASSERT_NEVER(a_in_ovf, cnt_q > InCntW'(InDepth))

endmodule

// ===== sv/ctk_back.sv =====
// scanner: token state machine, position tracking and result bundle
`include "assert_macros.svh"
module ctk_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctk_pkg::fq_t     fq_i,
  output logic             take_o,
  output ctk_pkg::oq_wr_t  oq_o,
  input  logic             oq_ready_i
);
  import ctk_pkg::*;

  typedef enum logic [8:0] {
    ModeStart  = 9'b000000001,
    ModeHeld   = 9'b000000010,
    ModeIdent  = 9'b000000100,
    ModeNumber = 9'b000001000,
    ModeString = 9'b000010000,
    ModeEscape = 9'b000100000,
    ModeLcom   = 9'b001000000,
    ModeBcom   = 9'b010000000,
    ModeDrain  = 9'b100000000
  } mode_e;

  typedef struct packed {
    logic vld;
    logic bang;
    res_t r;
  } fin_t;

  function automatic fin_t finish_tok(mode_e m, logic [7:0] h, logic [PrefixW-1:0] wp,
                                      logic [WlW-1:0] wl, logic [NumW-1:0] acc,
                                      logic [PosW-1:0] ln, logic [PosW-1:0] tc);
    fin_t f;
    f = '0;
    case (m)
      ModeIdent: begin
        f.vld = 1'b1;
        f.r   = mk_res(kw_kind(wp, wl), ErrUnexp, '0, '0, 1'b0, ln, tc);
      end
      ModeNumber: begin
        f.vld = 1'b1;
        f.r   = mk_res(KindNumber, ErrUnexp, acc, '0, 1'b0, ln, tc);
      end
      ModeHeld: begin
        f.vld = 1'b1;
        case (h)
          ChSlash: f.r = mk_res(KindSlash, ErrUnexp, '0, '0, 1'b0, ln, tc);
          ChEq:    f.r = mk_res(KindAssign, ErrUnexp, '0, '0, 1'b0, ln, tc);
          ChLt:    f.r = mk_res(KindLt, ErrUnexp, '0, '0, 1'b0, ln, tc);
          ChGt:    f.r = mk_res(KindGt, ErrUnexp, '0, '0, 1'b0, ln, tc);
          default: begin
            f.bang = 1'b1;
            f.r    = mk_res(KindError, ErrBang, '0, ChBang, 1'b0, ln, tc);
          end
        endcase
      end
      default: f = '0;
    endcase
    return f;
  endfunction

  mode_e                mode_q, mode_d;
  logic [7:0]           held_q, held_d;
  logic                 star_q, star_d;
  logic [PosW-1:0]      line_q, line_d, col_q, col_d, tcol_q, tcol_d;
  logic [NumW-1:0]      acc_q, acc_d;
  logic [PrefixW-1:0]   wp_q, wp_d;
  logic [WlW-1:0]       wl_q, wl_d;

  res_t                 step_r [BndDepth];
  logic [BndCntW-1:0]   step_n;
  res_t                 bnd_q [BndDepth];
  logic [BndCntW-1:0]   bnd_n_q, bnd_n_d;
  logic [BndIdxW-1:0]   bnd_rd_q, bnd_rd_d;

  class_t               it;
  logic [7:0]           ch;
  logic                 do_fin, do_beg, take, oq_wr;
  logic [NumW+3:0]      acc_ext, prod;
  logic [7:0]           esc;
  logic [KindW-1:0]     eq_kind;
  fin_t                 f_main, f_end;
  logic                 fin_take, pos_home;

  assign it      = fq_i.item;
  assign ch      = it.ch;
  assign acc_ext = {4'b0, acc_q};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + (NumW+4)'(ch[3:0]);

  always_comb begin
    case (ch)
      "n":     esc = ChNl;
      "t":     esc = ChTab;
      "r":     esc = ChCr;
      default: esc = ch;
    endcase
    case (held_q)
      ChEq:    eq_kind = KindEq;
      ChBang:  eq_kind = KindNe;
      ChLt:    eq_kind = KindLe;
      default: eq_kind = KindGe;
    endcase
  end

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    star_d = star_q;
    line_d = line_q;
    col_d  = col_q;
    tcol_d = tcol_q;
    acc_d  = acc_q;
    wp_d   = wp_q;
    wl_d   = wl_q;
    step_n = '0;
    for (int i = 0; i < BndDepth; i++) begin
      step_r[i] = '0;
    end
    do_fin = 1'b0;
    do_beg = 1'b0;
    f_main = finish_tok(mode_q, held_q, wp_q, wl_q, acc_q, line_q, tcol_q);

    case (mode_q)
      ModeHeld: begin
        if (held_q == ChSlash && ch == ChSlash) begin
          mode_d = ModeLcom;
        end else if (held_q == ChSlash && ch == ChStar) begin
          mode_d = ModeBcom;
          star_d = 1'b0;
        end else if (ch == ChEq && held_q != ChSlash) begin
          step_r[step_n[BndIdxW-1:0]] = mk_res(eq_kind, ErrUnexp, '0, '0, 1'b0, line_q, tcol_q);
          step_n = step_n + BndCntW'(1);
          mode_d = ModeStart;
        end else if (held_q == ChBang) begin
          step_r[step_n[BndIdxW-1:0]] = mk_res(KindError, ErrBang, '0, ChBang, 1'b0,
                                               line_q, tcol_q);
          step_n = step_n + BndCntW'(1);
          mode_d = ModeDrain;
        end else begin
          do_fin = 1'b1;
          do_beg = 1'b1;
        end
      end
      ModeIdent: begin
        if (it.alpha || it.digit) begin
          if (wl_q < WlW'(KwChars)) wp_d = {wp_q[PrefixW-9:0], ch};
          if (wl_q <= WlW'(KwChars)) wl_d = wl_q + WlW'(1);
          step_r[step_n[BndIdxW-1:0]] = mk_res(KindIdent, ErrUnexp, '0, ch, 1'b1, line_q, tcol_q);
          step_n = step_n + BndCntW'(1);
        end else begin
          do_fin = 1'b1;
          do_beg = 1'b1;
        end
      end
      ModeNumber: begin
        if (it.digit) begin
          if (prod > (NumW+4)'(NumMax)) begin
            step_r[step_n[BndIdxW-1:0]] = mk_res(KindError, ErrRange, '0, ch, 1'b0,
                                                 line_q, tcol_q);
            step_n = step_n + BndCntW'(1);
            mode_d = ModeDrain;
          end else begin
            acc_d = prod[NumW-1:0];
          end
        end else begin
          do_fin = 1'b1;
          do_beg = 1'b1;
        end
      end
      ModeString: begin
        if (ch == ChQuote) begin
          step_r[step_n[BndIdxW-1:0]] = mk_res(KindString, ErrUnexp, '0, '0, 1'b0,
                                               line_q, tcol_q);
          step_n = step_n + BndCntW'(1);
          mode_d = ModeStart;
        end else if (ch == ChBslash) begin
          mode_d = ModeEscape;
        end else if (ch == ChNl) begin
          step_r[step_n[BndIdxW-1:0]] = mk_res(KindError, ErrUnterm, '0, ch, 1'b0,
                                               line_q, col_q);
          step_n = step_n + BndCntW'(1);
          mode_d = ModeDrain;
        end else begin
          step_r[step_n[BndIdxW-1:0]] = mk_res(KindString, ErrUnexp, '0, ch, 1'b1,
                                               line_q, tcol_q);
          step_n = step_n + BndCntW'(1);
        end
      end
      ModeEscape: begin
        step_r[step_n[BndIdxW-1:0]] = mk_res(KindString, ErrUnexp, '0, esc, 1'b1,
                                             line_q, tcol_q);
        step_n = step_n + BndCntW'(1);
        mode_d = ModeString;
      end
      ModeLcom: begin
        if (ch == ChNl) mode_d = ModeStart;
      end
      ModeBcom: begin
        if (star_q && ch == ChSlash) mode_d = ModeStart;
        star_d = ch == ChStar;
      end
      ModeDrain: begin
        mode_d = ModeDrain;
      end
      default: begin
        mode_d = ModeStart;
        do_beg = 1'b1;
      end
    endcase

    // finish the pending token before the new one starts
    if (do_fin) begin
      if (f_main.vld) begin
        step_r[step_n[BndIdxW-1:0]] = f_main.r;
        step_n = step_n + BndCntW'(1);
      end
      mode_d = f_main.bang ? ModeDrain : ModeStart;
    end

    if (do_beg) begin
      tcol_d = col_q;
      if (it.space) begin
        mode_d = mode_d;
      end else if (it.alpha) begin
        mode_d = ModeIdent;
        wp_d   = PrefixW'(ch);
        wl_d   = WlW'(1);
        step_r[step_n[BndIdxW-1:0]] = mk_res(KindIdent, ErrUnexp, '0, ch, 1'b1, line_q, col_q);
        step_n = step_n + BndCntW'(1);
      end else if (it.digit) begin
        mode_d = ModeNumber;
        acc_d  = NumW'(ch[3:0]);
      end else if (ch == ChQuote) begin
        mode_d = ModeString;
      end else if (it.punct != KindEnd) begin
        step_r[step_n[BndIdxW-1:0]] = mk_res(it.punct, ErrUnexp, '0, '0, 1'b0, line_q, col_q);
        step_n = step_n + BndCntW'(1);
      end else if (it.held) begin
        mode_d = ModeHeld;
        held_d = ch;
      end else begin
        step_r[step_n[BndIdxW-1:0]] = mk_res(KindError, ErrUnexp, '0, ch, 1'b0, line_q, col_q);
        step_n = step_n + BndCntW'(1);
        mode_d = ModeDrain;
      end
    end

    if (ch == ChNl) begin
      if (line_q != PosMax) line_d = line_q + PosW'(1);
      col_d = PosW'(1);
    end else if (col_q != PosMax) begin
      col_d = col_q + PosW'(1);
    end

    f_end = finish_tok(mode_d, held_d, wp_d, wl_d, acc_d, line_d, tcol_d);
    if (it.fin) begin
      if (mode_d == ModeString || mode_d == ModeEscape) begin
        step_r[step_n[BndIdxW-1:0]] = mk_res(KindError, ErrUnterm, '0, '0, 1'b0, line_d, col_d);
        step_n = step_n + BndCntW'(1);
      end else if (mode_d != ModeDrain && f_end.vld) begin
        step_r[step_n[BndIdxW-1:0]] = f_end.r;
        step_n = step_n + BndCntW'(1);
      end
      step_r[step_n[BndIdxW-1:0]] = mk_res(KindEnd, ErrUnexp, '0, '0, 1'b0, line_d, col_d);
      step_n = step_n + BndCntW'(1);
      mode_d = ModeStart;
      held_d = '0;
      star_d = 1'b0;
      line_d = PosW'(1);
      col_d  = PosW'(1);
      tcol_d = PosW'(1);
      acc_d  = '0;
      wp_d   = '0;
      wl_d   = '0;
    end

    if (step_n != '0) begin
      step_r[BndIdxW'(step_n - BndCntW'(1))].last = 1'b1;
    end
  end

  // result bundle drains one transaction per cycle into the output queue while it has room
  assign oq_o.valid = bnd_n_q != '0;
  assign oq_o.data  = bnd_q[bnd_rd_q];
  assign oq_wr      = oq_o.valid && oq_ready_i;
  assign take       = fq_i.valid && (bnd_n_q == '0 || (bnd_n_q == BndCntW'(1) && oq_ready_i));
  assign take_o     = take;

  assign fin_take = take && it.fin;
  assign pos_home = mode_q == ModeStart && line_q == PosW'(1) && col_q == PosW'(1);

  always_comb begin
    bnd_n_d  = bnd_n_q;
    bnd_rd_d = bnd_rd_q;
    if (take) begin
      bnd_n_d  = step_n;
      bnd_rd_d = '0;
    end else if (oq_wr) begin
      bnd_n_d  = bnd_n_q - BndCntW'(1);
      bnd_rd_d = bnd_rd_q + BndIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeStart;
      held_q   <= '0;
      star_q   <= 1'b0;
      line_q   <= PosW'(1);
      col_q    <= PosW'(1);
      tcol_q   <= PosW'(1);
      acc_q    <= '0;
      wp_q     <= '0;
      wl_q     <= '0;
      bnd_n_q  <= '0;
      bnd_rd_q <= '0;
    end else begin
      bnd_n_q  <= bnd_n_d;
      bnd_rd_q <= bnd_rd_d;
      if (take) begin
        mode_q <= mode_d;
        held_q <= held_d;
        star_q <= star_d;
        line_q <= line_d;
        col_q  <= col_d;
        tcol_q <= tcol_d;
        acc_q  <= acc_d;
        wp_q   <= wp_d;
        wl_q   <= wl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < BndDepth; i++) begin
        bnd_q[i] <= step_r[i];
      end
    end
  end

  `ASSERT_PROP(a_fin_resets, fin_take |=> pos_home)
  `ASSERT_NEVER(a_pos_zero, line_q == '0 || col_q == '0 || tcol_q == '0)
  `ASSERT_PROP(a_drain_sticky, (mode_q == ModeDrain && !fin_take) |=> mode_q == ModeDrain)

endmodule

// ===== sv/ctk_outq.sv =====
// output queue of result transactions
`include "assert_macros.svh"
module ctk_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctk_pkg::oq_wr_t  wr_i,
  output logic             ready_o,
  output logic             empty_o,
  input  logic             pop_i,
  output ctk_pkg::res_t    result_o
);
  import ctk_pkg::*;

  res_t                mem_q [OutDepth];
  logic [OutPtrW-1:0]  wptr_q, rptr_q;
  logic [OutCntW-1:0]  cnt_q;
  logic                wr, rd;

  assign ready_o  = cnt_q != OutCntW'(OutDepth);
  assign empty_o  = cnt_q == '0;
  assign wr       = wr_i.valid && ready_o;
  assign rd       = pop_i && !empty_o;
  assign result_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + OutPtrW'(1);
      if (rd) rptr_q <= rptr_q + OutPtrW'(1);
      cnt_q <= cnt_q + OutCntW'(wr) - OutCntW'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_i.data;
    end
  end

  `ASSERT_NEVER(a_out_ovf, cnt_q > OutCntW'(OutDepth))
  `ASSERT_PROP(a_pop_drops, (rd && !wr) |=> cnt_q == $past(cnt_q) - OutCntW'(1))

endmodule

// ===== verif/c_subset_tokenizer_top_tb.sv =====
// testbench for the c subset tokenizer: directed sources and random programs
`timescale 1ns / 1ps

module c_subset_tokenizer_top_tb;
  import ctk_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int RandItems  = 265;

  typedef enum logic [3:0] {
    ScanStart, ScanHeld, ScanIdent, ScanNumber, ScanString, ScanEscape,
    ScanLineCmt, ScanBlockCmt, ScanDrain
  } scan_e;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  in_t  source_item;
  logic empty;
  logic pop = 1'b0;
  res_t token_out;

  // scanner state of the predictor
  scan_e           lex_mode;
  logic [7:0]      held_op;
  logic            star_prev;
  logic [PosW-1:0] cur_line;
  logic [PosW-1:0] cur_col;
  logic [PosW-1:0] tok_col;
  logic [NumW-1:0] num_acc;
  logic [47:0]     word_bits;
  logic [3:0]      word_len;

  res_t       byte_results[$];
  res_t       expected_tokens[$];
  logic [7:0] source_q[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_max = 6;
  logic [15:0] pop_tick = '0;

  string letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string keywords[5] = '{"int", "return", "if", "else", "while"};
  string op_text[8] = '{"=", "==", "!=", "<", "<=", ">", ">=", "/"};
  logic [7:0] blank_set[6] = '{" ", ChTab, ChNl, ChCr, 8'h0b, 8'h0c};

  c_subset_tokenizer_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_data_i(source_item),
    .empty    (empty),
    .pop      (pop),
    .result_o (token_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_lexer();
    lex_mode  = ScanStart;
    held_op   = '0;
    star_prev = 1'b0;
    cur_line  = PosW'(1);
    cur_col   = PosW'(1);
    tok_col   = PosW'(1);
    num_acc   = '0;
    word_bits = '0;
    word_len  = '0;
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == " " || (b >= ChTab && b <= ChCr);
  endfunction

  function automatic void add_result(logic [KindW-1:0] k, logic [ErrW-1:0] e,
                                     logic [NumW-1:0] n, logic [7:0] t, logic tv,
                                     logic [PosW-1:0] c);
    res_t r;
    r.kind         = k;
    r.error_code   = e;
    r.number_value = n;
    r.text_byte    = t;
    r.text_valid   = tv;
    r.line         = cur_line;
    r.column       = c;
    r.last         = 1'b0;
    if (byte_results.size() < 4) byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void put_token(logic [KindW-1:0] k);
    add_result(k, '0, '0, '0, 1'b0, tok_col);
  endfunction

  function automatic void raise_error(logic [ErrW-1:0] e, logic [7:0] t, logic [PosW-1:0] c);
    add_result(KindError, e, '0, t, 1'b0, c);
    lex_mode = ScanDrain;
  endfunction

  function automatic logic [KindW-1:0] word_token();
    if (word_len == 4'd3 && word_bits == {24'd0, "int"}) return KindInt;
    if (word_len == 4'd6 && word_bits == "return") return KindReturn;
    if (word_len == 4'd2 && word_bits == {32'd0, "if"}) return KindIf;
    if (word_len == 4'd4 && word_bits == {16'd0, "else"}) return KindElse;
    if (word_len == 4'd5 && word_bits == {8'd0, "while"}) return KindWhile;
    return KindIdent;
  endfunction

  function automatic void flush_pending();
    case (lex_mode)
      ScanIdent: put_token(word_token());
      ScanNumber: add_result(KindNumber, '0, num_acc, '0, 1'b0, tok_col);
      ScanHeld: begin
        case (held_op)
          ChSlash: put_token(KindSlash);
          ChEq: put_token(KindAssign);
          ChLt: put_token(KindLt);
          ChGt: put_token(KindGt);
          default: begin
            raise_error(ErrBang, ChBang, tok_col);
            return;
          end
        endcase
      end
      default: ;
    endcase
    lex_mode = ScanStart;
  endfunction

  function automatic void start_token(logic [7:0] b, logic [PosW-1:0] c);
    tok_col = c;
    if (is_blank(b)) return;
    if (is_letter(b)) begin
      lex_mode  = ScanIdent;
      word_bits = {40'd0, b};
      word_len  = 4'd1;
      add_result(KindIdent, '0, '0, b, 1'b1, c);
      return;
    end
    if (is_digit(b)) begin
      lex_mode = ScanNumber;
      num_acc  = NumW'(b - "0");
      return;
    end
    case (b)
      ChQuote: lex_mode = ScanString;
      "(": put_token(KindLparen);
      ")": put_token(KindRparen);
      "{": put_token(KindLbrace);
      "}": put_token(KindRbrace);
      ",": put_token(KindComma);
      ";": put_token(KindSemi);
      "+": put_token(KindPlus);
      "-": put_token(KindMinus);
      "*": put_token(KindStar);
      ChSlash, ChEq, ChBang, ChLt, ChGt: begin
        lex_mode = ScanHeld;
        held_op  = b;
      end
      default: raise_error(ErrUnexp, b, c);
    endcase
  endfunction

  function automatic void tokenize_byte(in_t it);
    logic [7:0]      b;
    logic [7:0]      d;
    logic [PosW-1:0] c;
    logic [35:0]     grown;
    b = it.byte_req;
    c = cur_col;
    byte_results.delete();
    case (lex_mode)
      ScanHeld: begin
        if (held_op == ChSlash && b == ChSlash) lex_mode = ScanLineCmt;
        else if (held_op == ChSlash && b == ChStar) begin
          lex_mode  = ScanBlockCmt;
          star_prev = 1'b0;
        end else if (b == ChEq && held_op != ChSlash) begin
          case (held_op)
            ChEq: put_token(KindEq);
            ChBang: put_token(KindNe);
            ChLt: put_token(KindLe);
            default: put_token(KindGe);
          endcase
          lex_mode = ScanStart;
        end else if (held_op == ChBang) raise_error(ErrBang, ChBang, tok_col);
        else begin
          flush_pending();
          start_token(b, c);
        end
      end
      ScanIdent: begin
        if (is_letter(b) || is_digit(b)) begin
          if (word_len < KwChars) word_bits = (word_bits << 8) | 48'(b);
          if (word_len <= KwChars) word_len++;
          add_result(KindIdent, '0, '0, b, 1'b1, tok_col);
        end else begin
          flush_pending();
          start_token(b, c);
        end
      end
      ScanNumber: begin
        if (is_digit(b)) begin
          grown = 36'(num_acc) * 36'd10 + 36'(b - "0");
          if (grown > 36'(NumMax)) raise_error(ErrRange, b, tok_col);
          else num_acc = grown[NumW-1:0];
        end else begin
          flush_pending();
          start_token(b, c);
        end
      end
      ScanString: begin
        if (b == ChQuote) begin
          put_token(KindString);
          lex_mode = ScanStart;
        end else if (b == ChBslash) lex_mode = ScanEscape;
        else if (b == ChNl) raise_error(ErrUnterm, b, c);
        else add_result(KindString, '0, '0, b, 1'b1, tok_col);
      end
      ScanEscape: begin
        case (b)
          "n": d = ChNl;
          "t": d = ChTab;
          "r": d = ChCr;
          default: d = b;
        endcase
        add_result(KindString, '0, '0, d, 1'b1, tok_col);
        lex_mode = ScanString;
      end
      ScanLineCmt: begin
        if (b == ChNl) lex_mode = ScanStart;
      end
      ScanBlockCmt: begin
        if (star_prev && b == ChSlash) lex_mode = ScanStart;
        star_prev = (b == ChStar);
      end
      ScanDrain: ;
      default: begin
        lex_mode = ScanStart;
        start_token(b, c);
      end
    endcase

    if (b == ChNl) begin
      if (cur_line != PosMax) cur_line++;
      cur_col = PosW'(1);
    end else if (cur_col != PosMax) begin
      cur_col++;
    end

    if (it.last_of_source) begin
      if (lex_mode == ScanString || lex_mode == ScanEscape) raise_error(ErrUnterm, '0, cur_col);
      else if (lex_mode != ScanDrain) flush_pending();
      add_result(KindEnd, '0, '0, '0, 1'b0, cur_col);
      reset_lexer();
    end

    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
    foreach (byte_results[i]) expected_tokens.insert(expected_tokens.size(), byte_results[i]);
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_t it;
    int  gap;
    it.byte_req       = b;
    it.last_of_source = fin;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
    end
    push        <= 1'b1;
    source_item <= it;
    do @(posedge clk_i); while (full);
    burst_left--;
    tokenize_byte(it);
  endtask

  task automatic send_source();
    for (int i = 0; i < source_q.size(); i++) send_byte(source_q[i], i == source_q.size() - 1);
    source_q.delete();
  endtask

  function automatic void add_byte(logic [7:0] b);
    source_q.insert(source_q.size(), b);
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // one lexical element of a random program, mostly well formed
  function automatic void add_fragment();
    int         r;
    int         n;
    longint     v;
    string      s;
    logic [7:0] ch;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = $urandom_range(0, 9);
      s = keywords[$urandom_range(0, 4)];
      if (n < 4) append_text(s);
      else if (n < 6) begin
        append_text(s);
        add_byte(pick(alnum));
      end else if (n == 6) append_text(s.substr(0, s.len() - 2));
      else begin
        add_byte(pick(letters));
        repeat ($urandom_range(0, 9)) add_byte(pick(alnum));
      end
    end else if (r < 34) begin
      n = $urandom_range(0, 9);
      if (n < 5) v = $urandom_range(0, 999);
      else if (n < 8) v = $urandom & 32'h7fff_ffff;
      else v = 64'd2147483647;
      if (n == 9) begin
        if ($urandom_range(0, 1) == 1) append_text("2147483648");
        else append_text($sformatf("%0d%0d", $urandom_range(100000, 999999),
                                   $urandom_range(10000, 99999)));
      end else append_text($sformatf("%0d", v));
    end else if (r < 46) begin
      add_byte(ChQuote);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(0, 9);
        if (n < 6) begin
          ch = 8'($urandom_range(32, 126));
          if (ch == ChQuote || ch == ChBslash) ch = "x";
          add_byte(ch);
        end else if (n < 8) begin
          add_byte(ChBslash);
          add_byte(pick("ntr\\\"a0"));
        end else if (n == 8) begin
          add_byte(ChBslash);
          add_byte(ChNl);
        end else add_byte(8'($urandom_range(128, 255)));
      end
      if ($urandom_range(0, 19) != 0) add_byte(ChQuote);
    end else if (r < 60) begin
      add_byte(pick("(){},;+-*"));
    end else if (r < 72) begin
      append_text(op_text[$urandom_range(0, 7)]);
    end else if (r < 82) begin
      n = $urandom_range(0, 3);
      case (n)
        0: append_text("//");
        1: append_text("/*");
        2: append_text("/*/");
        default: append_text("/**");
      endcase
      repeat ($urandom_range(0, 5)) add_byte(pick("ab1 */;\"x"));
      if (n == 0) add_byte(ChNl);
      else append_text((n == 3) ? "**/" : "*/");
    end else if (r < 94) begin
      repeat ($urandom_range(1, 4)) add_byte(blank_set[$urandom_range(0, 5)]);
    end else begin
      case ($urandom_range(0, 3))
        0: add_byte(8'($urandom_range(0, 255)));
        1: begin
          add_byte(ChBang);
          add_byte(pick("ab( 1!"));
        end
        2: append_text("\"a\n");
        default: add_byte(pick("@#$%`~?:.[]^&|'"));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_operators();
    append_text("(){},;+-*<=>=!===<>/=");
    send_source();
  endtask

  task automatic test_number_range();
    append_text("2147483648");
    send_source();
  endtask

  task automatic test_string_escapes();
    append_text("\"\\\n\n");
    send_source();
    append_text("\"a");
    send_source();
  endtask

  task automatic test_error_bytes();
    append_text("!x");
    send_source();
    add_byte(8'hff);
    send_source();
  endtask

  task automatic test_block_comment();
    append_text("/*/a");
    send_source();
  endtask

  task automatic test_random_programs();
    int sent;
    sent = 0;
    while (sent < RandItems) begin
      repeat ($urandom_range(1, 14)) begin
        add_fragment();
        if ($urandom_range(0, 9) < 6) add_byte(" ");
      end
      sent += source_q.size();
      send_source();
    end
  endtask

  // ---------------------------------------------------------------- result side

  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else begin
      pop_tick <= pop_tick + 16'd1;
      case (pop_tick[8:7])
        2'd0: pop <= 1'b1;
        2'd1: pop <= ($urandom_range(0, 3) != 0);
        2'd2: pop <= ((pop_tick % 7) < 3);
        default: pop <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic string describe(res_t r);
    return $sformatf("kind=%0d err=%0d num=%0d text=%02h tv=%0b line=%0d col=%0d last=%0b",
                     r.kind, r.error_code, r.number_value, r.text_byte, r.text_valid,
                     r.line, r.column, r.last);
  endfunction

  always @(posedge clk_i) begin : token_check
    res_t  want;
    string bad;
    if (rst_ni && pop && !empty) begin
      want = '0;
      bad  = "";
      if (expected_tokens.size() == 0) bad = " no transaction expected";
      else begin
        want = expected_tokens.pop_front();
        if (token_out.kind !== want.kind) bad = {bad, " kind"};
        if (token_out.error_code !== want.error_code) bad = {bad, " error_code"};
        if (token_out.number_value !== want.number_value) bad = {bad, " number_value"};
        if (token_out.text_byte !== want.text_byte) bad = {bad, " text_byte"};
        if (token_out.text_valid !== want.text_valid) bad = {bad, " text_valid"};
        if (token_out.line !== want.line) bad = {bad, " line"};
        if (token_out.column !== want.column) bad = {bad, " column"};
        if (token_out.last !== want.last) bad = {bad, " last"};
      end
      if (bad != "") begin
        if (mismatch_count < 10)
          $display("mismatch at cycle %0d:%s\n  expected %s\n  actual   %s",
                   cycle_count, bad, describe(want), describe(token_out));
        mismatch_count++;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : run
    rst_ni      = 1'b0;
    push        = 1'b0;
    source_item = '0;
    reset_lexer();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_operators();
    test_number_range();
    test_string_escapes();
    test_error_bytes();
    test_block_comment();
    test_random_programs();

    push <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0 && expected_tokens.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
